/* design/bfrm_pkg.sv */
package bfrm_pkg;

	localparam int DEPTH = 256;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CAP_W = 9;
	localparam int CNT_W = 9;
	localparam int IN_W  = 16;
	localparam int OUT_W = 24;

	localparam logic [2:0] OP_PUSH      = 3'd0;
	localparam logic [2:0] OP_POP       = 3'd1;
	localparam logic [2:0] OP_PROT_ON   = 3'd2;
	localparam logic [2:0] OP_PROT_OFF  = 3'd3;
	localparam logic [2:0] OP_REWIND    = 3'd4;
	localparam logic [2:0] OP_RESET     = 3'd5;

	localparam logic [7:0]       FAIL_BYTE = 8'hFF;
	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [PTR_W-1:0] raddr;
	} ram_req_t;

	function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
		logic [CAP_W-1:0] r;
		r = c;
		if (c == '0) r = CAP_W'(1);
		else if (c > CAP_W'(DEPTH)) r = CAP_W'(DEPTH);
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p,
			input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] n;
		n = CAP_W'(p) + CAP_W'(1);
		return (n >= cap) ? '0 : n[PTR_W-1:0];
	endfunction

endpackage

/* design/byte_fifo_with_rewind_mark.sv */
// A result beat is registered once the input beat is taken, the head entry read
// and the output register free; a rewind first walks the head back, up to capacity
// steps. The input is not ready for a new beat until the last result is registered;
// a rewind holds the input for the length of its walk.
// Reset: arst_n clears pointers, count, protect flag and output valid; capacity
// returns to 256. Storage contents are not cleared.
module byte_fifo_with_rewind_mark
	import bfrm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             s_tvalid,
	output logic             s_tready,
	// opcode[2:0], push_byte[10:3], zero fill above
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// ok[0], pop_byte[8:1], fill_count[17:9], is_empty[18], is_full[19], zero fill above
	output logic [OUT_W-1:0] m_tdata
);

	logic [CAP_W-1:0] cap_q;
	ram_req_t         ram_req;
	logic [7:0]       rd_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(DEPTH);
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	bfrm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cap_reg  (cap_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.ram_req  (ram_req),
		.rd_data  (rd_data)
	);

	bfrm_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

endmodule

/* design/bfrm_ram.sv */
module bfrm_ram
	import bfrm_pkg::*;
(
	input  logic       clk,
	input  ram_req_t   req,
	output logic [7:0] rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

/* design/bfrm_core.sv */
module bfrm_core
	import bfrm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CAP_W-1:0] cap_reg,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output ram_req_t         ram_req,
	input  logic [7:0]       rd_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_REW  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]       state_q;
	logic [2:0]       op_q;
	logic [7:0]       byte_q;
	logic [PTR_W-1:0] head_q, tail_q, mark_q;
	logic [CNT_W-1:0] cnt_q;
	logic             prot_q;
	logic [CAP_W-1:0] steps_q;
	logic             out_vld_q;
	logic [OUT_W-1:0] out_data_q;

	logic [CAP_W-1:0] cap;
	logic [PTR_W-1:0] nxt_head, nxt_tail, nxt_mark, head_dec;
	logic [CNT_W-1:0] nxt_cnt;
	logic             nxt_prot;
	logic             ok;
	logic [7:0]       pop_byte;
	logic             full, out_free, commit, go_rew, rew_step;

	assign cap      = eff_cap(cap_reg);
	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign go_rew   = (state_q == S_EXEC) && (op_q == OP_REWIND) && prot_q;
	assign commit   = out_free && (((state_q == S_EXEC) && !go_rew) || (state_q == S_FIN));
	assign rew_step = (head_q != mark_q) && (steps_q < cap);
	assign head_dec = (head_q == '0) ? PTR_W'(cap - CAP_W'(1)) : head_q - PTR_W'(1);

	always_comb begin
		nxt_head = head_q;
		nxt_tail = tail_q;
		nxt_mark = mark_q;
		nxt_cnt  = cnt_q;
		nxt_prot = prot_q;
		ok       = 1'b1;
		pop_byte = FAIL_BYTE;
		ram_req.we    = 1'b0;
		ram_req.waddr = tail_q;
		ram_req.wdata = byte_q;
		ram_req.re    = (state_q == S_IDLE);
		ram_req.raddr = head_q;
		if (state_q == S_EXEC) begin
			case (op_q)
				OP_PUSH: begin
					if (CAP_W'(cnt_q) < cap) begin
						ram_req.we = commit;
						nxt_tail   = bump(tail_q, cap);
						nxt_cnt    = cnt_q + CNT_W'(1);
					end else begin
						ok = 1'b0;
					end
				end
				OP_POP: begin
					if (cnt_q != '0) begin
						pop_byte = rd_data;
						nxt_head = bump(head_q, cap);
						nxt_cnt  = cnt_q - CNT_W'(1);
					end else begin
						ok = 1'b0;
					end
				end
				OP_PROT_ON: begin
					nxt_prot = 1'b1;
					nxt_mark = head_q;
				end
				OP_PROT_OFF: begin
					nxt_prot = 1'b0;
				end
				OP_RESET: begin
					nxt_head = '0;
					nxt_tail = '0;
					nxt_mark = '0;
					nxt_cnt  = '0;
					nxt_prot = 1'b0;
				end
				default: begin
				end
			endcase
		end
		full = (CAP_W'(nxt_cnt) >= cap) ||
			(nxt_prot && (nxt_cnt != '0) && (nxt_tail == nxt_mark));
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= s_tdata[2:0];
			byte_q <= s_tdata[10:3];
		end
		if (commit) begin
			out_data_q <= {4'b0, full, (nxt_cnt == '0), nxt_cnt, pop_byte, ok};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			mark_q    <= '0;
			cnt_q     <= '0;
			prot_q    <= 1'b0;
			steps_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go_rew) begin
						steps_q <= '0;
						state_q <= S_REW;
					end else if (commit) begin
						head_q  <= nxt_head;
						tail_q  <= nxt_tail;
						mark_q  <= nxt_mark;
						cnt_q   <= nxt_cnt;
						prot_q  <= nxt_prot;
						state_q <= S_IDLE;
					end
				end
				S_REW: begin
					if (rew_step) begin
						head_q  <= head_dec;
						steps_q <= steps_q + CAP_W'(1);
						if (cnt_q != CNT_MAX) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (head_dec == tail_q) begin
							state_q <= S_FIN;
						end
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

`ifndef ASSERT_OFF
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_EXEC))
		else $error("accepted beat did not enter execution");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (state_q == S_EXEC) && (op_q == OP_PUSH) && ok)
		|=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("successful push did not raise the count");
	a_rew_prot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REW) |-> prot_q)
		else $error("rewind walk without protect");
	a_rew_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REW) |-> (steps_q <= cap))
		else $error("rewind walk exceeded capacity");
`endif

endmodule
